/* hw/rtl/hstb_pkg.sv */
// ----------------------------------------------------------------------------
// hstb_pkg
// Shared widths, request and status codes, and the control bundles that pass
// between the slot table controller and its datapath.
// ----------------------------------------------------------------------------
package hstb_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    // free-slot search looks at this many slots per cycle
    localparam int SCAN_CHUNK = 16;
    localparam int SCAN_PW    = 4;

    localparam int REQ_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int MODE_W  = 2;
    localparam int SIZE_W  = 62;
    localparam int BYTES_W = 31;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_OPEN     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLOSE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SHUTDOWN = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OPEN    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FREE = 2'd0;

    localparam logic [OCNT_W-1:0] OPEN_COUNT_MAX = 5'd31;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic commit;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_open;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/hstb_ctrl.sv */
// ----------------------------------------------------------------------------
// hstb_ctrl
// Request sequencer: accepts a request, steps the free-slot search, commits
// the table update and hands the result to the output register.
// ----------------------------------------------------------------------------
module hstb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hstb_pkg::t_sts i_sts,
    output hstb_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // keep searching while the current chunk has no free slot
                if (i_sts.is_open && !i_sts.scan_hit && !i_sts.scan_last) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

/* hw/rtl/hstb_dp.sv */
// ----------------------------------------------------------------------------
// hstb_dp
// Slot table datapath: used flags, open counter, budget memory with valid
// bits, chunked free-slot search, read budget arithmetic, output register.
// ----------------------------------------------------------------------------
module hstb_dp #(
    parameter int SLOT_COUNT = hstb_pkg::SLOT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hstb_pkg::t_cmd               i_cmd,
    output hstb_pkg::t_sts               o_sts,
    input  logic [hstb_pkg::REQ_W-1:0]   i_in_req_type,
    input  logic [hstb_pkg::SLOT_W-1:0]  i_in_slot,
    input  logic [hstb_pkg::MODE_W-1:0]  i_in_open_mode,
    input  logic [hstb_pkg::SIZE_W-1:0]  i_in_file_size,
    input  logic [hstb_pkg::BYTES_W-1:0] i_in_byte_count,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [hstb_pkg::STAT_W-1:0]  o_out_status,
    output logic [hstb_pkg::SLOT_W-1:0]  o_out_slot_out,
    output logic [hstb_pkg::BYTES_W-1:0] o_out_bytes_done,
    output logic [hstb_pkg::OCNT_W-1:0]  o_out_open_count
);

    localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int NCHUNK = (SLOT_COUNT + hstb_pkg::SCAN_CHUNK - 1) / hstb_pkg::SCAN_CHUNK;
    localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int FW     = CIW + hstb_pkg::SCAN_PW;
    localparam int XW     = (SW > hstb_pkg::SLOT_W) ? SW + 1 : hstb_pkg::SLOT_W + 1;
    localparam int EW     = (CW > hstb_pkg::OCNT_W) ? CW : hstb_pkg::OCNT_W;
    localparam int PADW   = NCHUNK * hstb_pkg::SCAN_CHUNK;

    // latched request
    logic [hstb_pkg::REQ_W-1:0]   r_req_type;
    logic [hstb_pkg::MODE_W-1:0]  r_mode;
    logic [hstb_pkg::SIZE_W-1:0]  r_size;
    logic [hstb_pkg::BYTES_W-1:0] r_bytes;
    logic                         r_idx_ok;
    logic [SW-1:0]                r_addr;

    // table state
    logic [SLOT_COUNT-1:0]        r_used;
    logic [SLOT_COUNT-1:0]        n_used;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [hstb_pkg::SIZE_W-1:0]  r_budget_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]        r_budget_vld;
    logic [hstb_pkg::SIZE_W-1:0]  r_rd_data;
    logic                         r_rd_vld;
    logic [CIW-1:0]               r_chunk;

    // pending result and output register
    logic [hstb_pkg::STAT_W-1:0]  r_res_status;
    logic [hstb_pkg::SLOT_W-1:0]  r_res_slot;
    logic [hstb_pkg::BYTES_W-1:0] r_res_bytes;
    logic                         r_out_valid;
    logic [hstb_pkg::STAT_W-1:0]  r_out_status;
    logic [hstb_pkg::SLOT_W-1:0]  r_out_slot;
    logic [hstb_pkg::BYTES_W-1:0] r_out_bytes;
    logic [hstb_pkg::OCNT_W-1:0]  r_out_count;

    logic [XW-1:0]                in_idx_x;
    logic                         in_idx_ok;
    logic [SW-1:0]                in_addr;

    logic [PADW-1:0]              used_pad;
    logic [hstb_pkg::SCAN_CHUNK-1:0] free_chunk;
    logic [hstb_pkg::SCAN_PW-1:0] scan_pos;
    logic                         scan_hit;
    logic [FW-1:0]                found_x;
    logic [SW-1:0]                found;

    logic [hstb_pkg::SIZE_W-1:0]  budget;
    logic [hstb_pkg::BYTES_W-1:0] rd_take;
    logic [hstb_pkg::SIZE_W-1:0]  rd_left;

    logic                         is_open;
    logic                         is_read;
    logic                         is_close;
    logic                         open_claim;
    logic                         mem_we;
    logic [SW-1:0]                mem_wa;
    logic [hstb_pkg::SIZE_W-1:0]  mem_wd;

    logic [hstb_pkg::STAT_W-1:0]  res_status;
    logic [hstb_pkg::SLOT_W-1:0]  res_slot;
    logic [hstb_pkg::BYTES_W-1:0] res_bytes;
    logic [EW-1:0]                count_x;
    logic [hstb_pkg::OCNT_W-1:0]  count_sat;
    logic                         out_free;

    // ------------------------------------------------------------------
    // request index decode
    // ------------------------------------------------------------------
    assign in_idx_x  = XW'(i_in_slot);
    assign in_idx_ok = (in_idx_x < XW'(SLOT_COUNT));
    assign in_addr   = in_idx_ok ? SW'(in_idx_x) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_in_req_type;
            r_mode     <= i_in_open_mode;
            r_size     <= i_in_file_size;
            r_bytes    <= i_in_byte_count;
            r_idx_ok   <= in_idx_ok;
            r_addr     <= in_addr;
        end
    end

    assign is_open  = (r_req_type == hstb_pkg::REQ_OPEN);
    assign is_read  = (r_req_type == hstb_pkg::REQ_READ);
    assign is_close = (r_req_type == hstb_pkg::REQ_CLOSE);

    // ------------------------------------------------------------------
    // free-slot search, one chunk per cycle; slots past the end read as used
    // ------------------------------------------------------------------
    for (genvar g = 0; g < PADW; g++) begin : g_pad
        if (g < SLOT_COUNT) begin : g_slot
            assign used_pad[g] = r_used[g];
        end else begin : g_fill
            assign used_pad[g] = 1'b1;
        end
    end

    assign free_chunk = ~used_pad[r_chunk * hstb_pkg::SCAN_CHUNK +: hstb_pkg::SCAN_CHUNK];
    assign scan_hit   = |free_chunk;

    always_comb begin
        scan_pos = '0;
        for (int i = hstb_pkg::SCAN_CHUNK - 1; i >= 0; i--) begin
            if (free_chunk[i]) begin
                scan_pos = hstb_pkg::SCAN_PW'(i);
            end
        end
    end

    assign found_x = {r_chunk, scan_pos};
    assign found   = SW'(found_x);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_chunk <= '0;
        end else if (i_cmd.scan_step) begin
            r_chunk <= r_chunk + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // budget memory: registered read at accept, one write at commit
    // ------------------------------------------------------------------
    assign budget  = r_rd_vld ? r_rd_data : '0;
    assign rd_take = (hstb_pkg::SIZE_W'(r_bytes) < budget) ? r_bytes
                                                          : budget[hstb_pkg::BYTES_W-1:0];
    assign rd_left = budget - hstb_pkg::SIZE_W'(rd_take);

    assign open_claim = is_open && scan_hit;
    assign mem_we     = i_cmd.commit && (open_claim || (is_read && r_idx_ok));
    assign mem_wa     = is_open ? found : r_addr;
    assign mem_wd     = is_open ? r_size : rd_left;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_budget_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_budget_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget_vld <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (mem_we) begin
                r_budget_vld[mem_wa] <= 1'b1;
            end
            if (i_cmd.accept) begin
                r_rd_vld <= r_budget_vld[in_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // used flags and open counter
    // ------------------------------------------------------------------
    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        if (i_cmd.commit) begin
            if (open_claim && (r_mode != hstb_pkg::MODE_FREE)) begin
                n_used[found] = 1'b1;
                n_count       = r_count + 1'b1;
            end else if (is_close && r_idx_ok && r_used[r_addr]) begin
                n_used[r_addr] = 1'b0;
                n_count        = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // result
    // ------------------------------------------------------------------
    always_comb begin
        res_status = hstb_pkg::STAT_OK;
        res_slot   = '0;
        res_bytes  = '0;
        unique case (r_req_type)
            hstb_pkg::REQ_OPEN: begin
                if (scan_hit) begin
                    res_slot = hstb_pkg::SLOT_W'(found_x);
                end else begin
                    res_status = hstb_pkg::STAT_NO_SLOT;
                end
            end
            hstb_pkg::REQ_READ: begin
                if (r_idx_ok) begin
                    res_bytes = rd_take;
                end
            end
            hstb_pkg::REQ_WRITE: begin
                res_bytes = r_bytes;
            end
            hstb_pkg::REQ_SHUTDOWN: begin
                if (r_count != '0) begin
                    res_status = hstb_pkg::STAT_OPEN;
                end
            end
            default: begin
                res_status = hstb_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_status <= res_status;
            r_res_slot   <= res_slot;
            r_res_bytes  <= res_bytes;
        end
    end

    // counter is already updated when the result is pushed
    assign count_x   = EW'(r_count);
    assign count_sat = (count_x > EW'(hstb_pkg::OPEN_COUNT_MAX)) ? hstb_pkg::OPEN_COUNT_MAX
                                                                 : count_x[hstb_pkg::OCNT_W-1:0];

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_bytes  <= r_res_bytes;
            r_out_count  <= count_sat;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_status     = r_out_status;
    assign o_out_slot_out   = r_out_slot;
    assign o_out_bytes_done = r_out_bytes;
    assign o_out_open_count = r_out_count;

    assign o_sts.is_open   = is_open;
    assign o_sts.scan_hit  = scan_hit;
    assign o_sts.scan_last = (r_chunk == CIW'(NCHUNK - 1));
    assign o_sts.out_free  = out_free;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_used)))
        else $error("open counter disagrees with used flags");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOT_COUNT))
        else $error("open counter beyond table size");

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free)
        else $error("result pushed over a waiting result");

    a_open_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && open_claim && (r_mode != hstb_pkg::MODE_FREE))
            |=> r_used[$past(found)])
        else $error("claimed slot not marked used");

endmodule

/* hw/rtl/handle_slot_table_with_byte_budget.sv */
// Handle slot table with a per-slot byte budget. Each request (open, read,
// write, close, shutdown check) produces exactly one result. Requests are
// handled one at a time: the sequencer accepts a request, executes it (an
// open steps through 16-slot chunks until one holds a free slot or the last
// chunk is reached), commits the table update, pushes the result into the
// result register and returns to idle before it takes the next request; a
// full result register stalls the push. The result register lets the next
// request be accepted while a result still waits.
// Budgets live in a memory with a registered read port; per-slot valid bits
// make unwritten budgets read as zero right after reset, so no clearing pass.
// ----------------------------------------------------------------------------
// handle_slot_table_with_byte_budget
// Top level: request sequencer plus slot table datapath.
// ----------------------------------------------------------------------------
module handle_slot_table_with_byte_budget #(
    parameter int SLOT_COUNT = hstb_pkg::SLOT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [hstb_pkg::REQ_W-1:0]   i_req_type,
    input  logic [hstb_pkg::SLOT_W-1:0]  i_slot,
    input  logic [hstb_pkg::MODE_W-1:0]  i_open_mode,
    input  logic [hstb_pkg::SIZE_W-1:0]  i_file_size,
    input  logic [hstb_pkg::BYTES_W-1:0] i_byte_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hstb_pkg::STAT_W-1:0]  o_status,
    output logic [hstb_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [hstb_pkg::BYTES_W-1:0] o_bytes_done,
    output logic [hstb_pkg::OCNT_W-1:0]  o_open_count
);

    hstb_pkg::t_cmd cmd;
    hstb_pkg::t_sts sts;

    hstb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hstb_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_req_type    (i_req_type),
        .i_in_slot        (i_slot),
        .i_in_open_mode   (i_open_mode),
        .i_in_file_size   (i_file_size),
        .i_in_byte_count  (i_byte_count),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_status     (o_status),
        .o_out_slot_out   (o_slot_out),
        .o_out_bytes_done (o_bytes_done),
        .o_out_open_count (o_open_count)
    );

endmodule

/* tb/handle_slot_table_with_byte_budget_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handle_slot_table_with_byte_budget_tb
// Self-checking bench for the handle slot table. A short table of directed
// requests covers the field extremes, every request type, reads of free
// slots, opens with mode zero and unknown types. Random bursts
// follow that fill, drain and mix the table. Every result is compared with a
// predicted table kept in the bench, under varying sender gaps and receiver
// stalls, with one long receiver hold-off that backs up the request path.
// ----------------------------------------------------------------------------
module handle_slot_table_with_byte_budget_tb;

    localparam int NUM_SLOTS     = hstb_pkg::SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int PHASES        = 4;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 30;

    localparam logic [hstb_pkg::REQ_W-1:0]   REQ_BAD_LO = 3'd5;
    localparam logic [hstb_pkg::REQ_W-1:0]   REQ_BAD_MID = 3'd6;
    localparam logic [hstb_pkg::REQ_W-1:0]   REQ_BAD_HI = 3'd7;
    localparam logic [hstb_pkg::MODE_W-1:0]  MODE_INPUT = 2'd1;
    localparam logic [hstb_pkg::MODE_W-1:0]  MODE_OUTPUT = 2'd2;
    localparam logic [hstb_pkg::MODE_W-1:0]  MODE_UPDATE = 2'd3;
    localparam logic [hstb_pkg::SIZE_W-1:0]  SIZE_MAX = {hstb_pkg::SIZE_W{1'b1}};
    localparam logic [hstb_pkg::BYTES_W-1:0] BYTES_MAX = {hstb_pkg::BYTES_W{1'b1}};

    typedef struct packed {
        logic [hstb_pkg::REQ_W-1:0]   kind;
        logic [hstb_pkg::SLOT_W-1:0]  slot;
        logic [hstb_pkg::MODE_W-1:0]  mode;
        logic [hstb_pkg::SIZE_W-1:0]  size;
        logic [hstb_pkg::BYTES_W-1:0] nbytes;
    } t_req;

    typedef struct packed {
        logic [hstb_pkg::STAT_W-1:0]  status;
        logic [hstb_pkg::SLOT_W-1:0]  slot_out;
        logic [hstb_pkg::BYTES_W-1:0] bytes_done;
        logic [hstb_pkg::OCNT_W-1:0]  open_count;
    } t_rsp;

    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} t_mix;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [hstb_pkg::REQ_W-1:0]     i_req_type = '0;
    logic [hstb_pkg::SLOT_W-1:0]    i_slot = '0;
    logic [hstb_pkg::MODE_W-1:0]    i_open_mode = '0;
    logic [hstb_pkg::SIZE_W-1:0]    i_file_size = '0;
    logic [hstb_pkg::BYTES_W-1:0]   i_byte_count = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [hstb_pkg::STAT_W-1:0]    o_status;
    logic [hstb_pkg::SLOT_W-1:0]    o_slot_out;
    logic [hstb_pkg::BYTES_W-1:0]   o_bytes_done;
    logic [hstb_pkg::OCNT_W-1:0]    o_open_count;

    // predicted table contents
    logic [hstb_pkg::MODE_W-1:0]    mode_of[NUM_SLOTS];
    logic [hstb_pkg::SIZE_W-1:0]    budget_of[NUM_SLOTS];

    t_rsp                 due_results[$];
    t_dir_row             dir_rows[$];
    int                   n_err = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    bit                   long_hold_req = 1'b0;

    handle_slot_table_with_byte_budget dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_slot       (i_slot),
        .i_open_mode  (i_open_mode),
        .i_file_size  (i_file_size),
        .i_byte_count (i_byte_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_bytes_done (o_bytes_done),
        .o_open_count (o_open_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_req mk_req(logic [hstb_pkg::REQ_W-1:0] kind,
                                    logic [hstb_pkg::SLOT_W-1:0] slot,
                                    logic [hstb_pkg::MODE_W-1:0] mode,
                                    logic [hstb_pkg::SIZE_W-1:0] size,
                                    logic [hstb_pkg::BYTES_W-1:0] nbytes);
        t_req r;
        r.kind   = kind;
        r.slot   = slot;
        r.mode   = mode;
        r.size   = size;
        r.nbytes = nbytes;
        return r;
    endfunction

    function automatic t_rsp mk_rsp(logic [hstb_pkg::STAT_W-1:0] status,
                                    logic [hstb_pkg::SLOT_W-1:0] slot_out,
                                    logic [hstb_pkg::BYTES_W-1:0] bytes_done,
                                    logic [hstb_pkg::OCNT_W-1:0] open_count);
        t_rsp o;
        o.status     = status;
        o.slot_out   = slot_out;
        o.bytes_done = bytes_done;
        o.open_count = open_count;
        return o;
    endfunction

    function automatic void dir_add(t_req rq, bit typed, t_rsp want);
        t_dir_row row;
        row.rq    = rq;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void clear_table();
        int i;
        for (i = 0; i < NUM_SLOTS; i++) begin
            mode_of[i]   = hstb_pkg::MODE_FREE;
            budget_of[i] = '0;
        end
    endfunction

    // Apply one request to the predicted table and return its result.
    function automatic t_rsp apply_request(t_req r);
        t_rsp                        o;
        logic [hstb_pkg::SIZE_W-1:0] left;
        bit                          hit;
        int                          i;
        int                          n;
        o = '0;
        hit = 1'b0;
        case (r.kind)
            hstb_pkg::REQ_OPEN: begin
                for (i = 0; i < NUM_SLOTS; i++) begin
                    if (!hit && mode_of[i] == hstb_pkg::MODE_FREE) begin
                        // mode zero hands out the slot but leaves it free
                        mode_of[i]   = r.mode;
                        budget_of[i] = r.size;
                        o.slot_out   = i[hstb_pkg::SLOT_W-1:0];
                        hit = 1'b1;
                    end
                end
                if (!hit) o.status = hstb_pkg::STAT_NO_SLOT;
            end
            hstb_pkg::REQ_READ: begin
                // open mark is not checked on read
                left = budget_of[r.slot];
                if ({{(hstb_pkg::SIZE_W-hstb_pkg::BYTES_W){1'b0}}, r.nbytes} < left) begin
                    o.bytes_done = r.nbytes;
                end else begin
                    o.bytes_done = left[hstb_pkg::BYTES_W-1:0];
                end
                budget_of[r.slot] = left
                    - {{(hstb_pkg::SIZE_W-hstb_pkg::BYTES_W){1'b0}}, o.bytes_done};
            end
            hstb_pkg::REQ_WRITE: begin
                o.bytes_done = r.nbytes;
            end
            hstb_pkg::REQ_CLOSE: begin
                mode_of[r.slot] = hstb_pkg::MODE_FREE;
            end
            default: ;
        endcase
        n = 0;
        for (i = 0; i < NUM_SLOTS; i++) begin
            if (mode_of[i] != hstb_pkg::MODE_FREE) n++;
        end
        if (n > int'(hstb_pkg::OPEN_COUNT_MAX)) n = int'(hstb_pkg::OPEN_COUNT_MAX);
        if (r.kind == hstb_pkg::REQ_SHUTDOWN && n != 0) o.status = hstb_pkg::STAT_OPEN;
        o.open_count = n[hstb_pkg::OCNT_W-1:0];
        return o;
    endfunction

    function automatic t_req rand_request(t_mix mix);
        t_req r;
        int   pick;
        int   t_open;
        int   t_read;
        int   t_write;
        int   t_close;
        int   t_shut;
        case (mix)
            MIX_FILL: begin
                t_open = 50; t_read = 75; t_write = 83; t_close = 90; t_shut = 95;
            end
            MIX_DRAIN: begin
                t_open = 10; t_read = 30; t_write = 38; t_close = 88; t_shut = 95;
            end
            default: begin
                t_open = 25; t_read = 55; t_write = 65; t_close = 85; t_shut = 95;
            end
        endcase
        pick = $urandom_range(99);
        if (pick < t_open)       r.kind = hstb_pkg::REQ_OPEN;
        else if (pick < t_read)  r.kind = hstb_pkg::REQ_READ;
        else if (pick < t_write) r.kind = hstb_pkg::REQ_WRITE;
        else if (pick < t_close) r.kind = hstb_pkg::REQ_CLOSE;
        else if (pick < t_shut)  r.kind = hstb_pkg::REQ_SHUTDOWN;
        else r.kind = hstb_pkg::REQ_W'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
        r.slot = hstb_pkg::SLOT_W'($urandom);
        r.mode = ($urandom_range(9) == 0) ? hstb_pkg::MODE_FREE
                 : hstb_pkg::MODE_W'($urandom_range(MODE_UPDATE, MODE_INPUT));
        // keep most budgets and counts comparable so reads run budgets dry
        r.size   = ($urandom_range(9) < 7) ? hstb_pkg::SIZE_W'($urandom_range(2000))
                                           : hstb_pkg::SIZE_W'({$urandom, $urandom});
        r.nbytes = ($urandom_range(9) < 7) ? hstb_pkg::BYTES_W'($urandom_range(600))
                                           : hstb_pkg::BYTES_W'($urandom);
        return r;
    endfunction

    task automatic offer(t_req r, bit typed, t_rsp want);
        t_rsp e;
        i_in_valid   <= 1'b1;
        i_req_type   <= r.kind;
        i_slot       <= r.slot;
        i_open_mode  <= r.mode;
        i_file_size  <= r.size;
        i_byte_count <= r.nbytes;
        do @(negedge i_clk); while (o_in_stall);
        // request is taken at the coming edge
        e = apply_request(r);
        due_results.push_back(typed ? want : e);
        @(posedge i_clk);
    endtask

    task automatic idle_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // receiver stall, with one long hold-off owned by this process
    initial begin : out_stall_gen
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_taken) begin
                hold_left = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin : result_check
        t_rsp got;
        t_rsp want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = mk_rsp(o_status, o_slot_out, o_bytes_done, o_open_count);
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    n_err++;
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        n_err++;
                    end
                    if (got.slot_out !== want.slot_out) begin
                        $display("%0t: slot_out expected %0d got %0d",
                                 $time, want.slot_out, got.slot_out);
                        n_err++;
                    end
                    if (got.bytes_done !== want.bytes_done) begin
                        $display("%0t: bytes_done expected %0d got %0d",
                                 $time, want.bytes_done, got.bytes_done);
                        n_err++;
                    end
                    if (got.open_count !== want.open_count) begin
                        $display("%0t: open_count expected %0d got %0d",
                                 $time, want.open_count, got.open_count);
                        n_err++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int   k;
        int   phase;
        int   left;
        int   burst;
        t_mix mix;
        t_rsp none;
        none = '0;
        clear_table();

        // after reset
        dir_add(mk_req(hstb_pkg::REQ_SHUTDOWN, 4'd0, hstb_pkg::MODE_FREE, '0, '0), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd0));
        dir_add(mk_req(hstb_pkg::REQ_READ, 4'd15, MODE_UPDATE, SIZE_MAX, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd0));
        dir_add(mk_req(hstb_pkg::REQ_WRITE, 4'd15, MODE_UPDATE, SIZE_MAX, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, BYTES_MAX, 5'd0));
        dir_add(mk_req(hstb_pkg::REQ_WRITE, 4'd0, hstb_pkg::MODE_FREE, '0, '0), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd0));
        dir_add(mk_req(hstb_pkg::REQ_OPEN, 4'd9, MODE_INPUT, SIZE_MAX, 31'd5), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd1));
        // mode zero: slot 1 reported, stays free
        dir_add(mk_req(hstb_pkg::REQ_OPEN, 4'd0, hstb_pkg::MODE_FREE, 62'd100, '0), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd1, '0, 5'd1));
        // reads of a free slot drain its budget
        dir_add(mk_req(hstb_pkg::REQ_READ, 4'd1, hstb_pkg::MODE_FREE, '0, 31'd30), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_READ, 4'd1, hstb_pkg::MODE_FREE, '0, BYTES_MAX), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_READ, 4'd1, hstb_pkg::MODE_FREE, '0, 31'd5), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_READ, 4'd0, hstb_pkg::MODE_FREE, '0, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, BYTES_MAX, 5'd1));
        dir_add(mk_req(hstb_pkg::REQ_OPEN, 4'd0, MODE_OUTPUT, '0, '0), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd1, '0, 5'd2));
        dir_add(mk_req(hstb_pkg::REQ_OPEN, 4'd0, MODE_UPDATE, {31{2'b10}}, '0), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_OPEN, 4'd0, MODE_UPDATE, {31{2'b01}}, '0), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_SHUTDOWN, 4'd15, MODE_UPDATE, SIZE_MAX, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OPEN, 4'd0, '0, 5'd4));
        dir_add(mk_req(REQ_BAD_LO, 4'd15, MODE_UPDATE, SIZE_MAX, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd4));
        dir_add(mk_req(REQ_BAD_MID, 4'd0, MODE_INPUT, SIZE_MAX, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd4));
        dir_add(mk_req(REQ_BAD_HI, 4'd2, MODE_UPDATE, '0, BYTES_MAX), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd4));
        dir_add(mk_req(hstb_pkg::REQ_CLOSE, 4'd1, hstb_pkg::MODE_FREE, '0, '0), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_OPEN, 4'd0, MODE_INPUT, 62'd1234, '0), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_CLOSE, 4'd9, hstb_pkg::MODE_FREE, '0, '0), 0, none);
        dir_add(mk_req(hstb_pkg::REQ_READ, 4'd2, hstb_pkg::MODE_FREE, '0,
                       {1'b0, {15{2'b10}}}), 0, none);
        for (k = 0; k < 4; k++) begin
            dir_add(mk_req(hstb_pkg::REQ_CLOSE, k[hstb_pkg::SLOT_W-1:0],
                           hstb_pkg::MODE_FREE, '0, '0), 0, none);
        end
        dir_add(mk_req(hstb_pkg::REQ_SHUTDOWN, 4'd0, hstb_pkg::MODE_FREE, '0, '0), 1,
                mk_rsp(hstb_pkg::STAT_OK, 4'd0, '0, 5'd0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            offer(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            // back up the request path once, with the sender still pushing
            if (phase == 0) long_hold_req = 1'b1;
            left = RANDOM_ITEMS / PHASES;
            while (left > 0) begin
                mix = t_mix'($urandom_range(MIX_BLEND, MIX_FILL));
                burst = $urandom_range(60, 15);
                while (burst > 0 && left > 0) begin
                    idle_gap();
                    offer(rand_request(mix), 0, none);
                    burst--;
                    left--;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hstb_pkg.sv
hw/rtl/hstb_ctrl.sv
hw/rtl/hstb_dp.sv
hw/rtl/handle_slot_table_with_byte_budget.sv
tb/handle_slot_table_with_byte_budget_tb.sv
